// ===== hw/rtl/ps2ma_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet accumulator.
`default_nettype none

package ps2ma_pkg;

  // Default width of the running movement totals
  localparam int unsigned TOTAL_WIDTH_DEFAULT = 16;

  // Width of the reported movement fields
  localparam int unsigned DELTA_WIDTH = 16;

  // Width of one mouse byte and of the button field
  localparam int unsigned BYTE_WIDTH   = 8;
  localparam int unsigned BUTTON_WIDTH = 3;

  // Header bit positions
  localparam int unsigned HDR_SYNC_BIT   = 3;
  localparam int unsigned HDR_X_SIGN_BIT = 4;
  localparam int unsigned HDR_Y_SIGN_BIT = 5;

  // Input operation codes
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Result event kinds
  typedef enum logic {
    EV_DELTA  = 1'b0,
    EV_BUTTON = 1'b1
  } event_kind_t;

  // Position within the three-byte packet, one-hot
  typedef enum logic [2:0] {
    POS_HEADER = 3'b001,
    POS_X      = 3'b010,
    POS_Y      = 3'b100
  } pos_t;

  // One result event
  typedef struct packed {
    event_kind_t                    kind;
    logic signed [DELTA_WIDTH-1:0]  dx;
    logic signed [DELTA_WIDTH-1:0]  dy;
    logic [BUTTON_WIDTH-1:0]        buttons;
    logic                           last;
  } event_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ps2_mouse_packet_accumulator.sv =====
// Top level: PS/2 mouse packet assembly, movement accumulation and event output.
`default_nettype none

// Takes one raw PS/2 mouse byte or one idle tick per input transfer. Bytes are
// gathered into header/X/Y packets (a header without bit 3 set is dropped);
// the header sets the buttons, the Y byte adds X to and subtracts Y from two
// saturating TOTAL_WIDTH-bit totals. An idle tick emits a delta event if a
// total is nonzero (then clears both) and a button event if the buttons
// changed since the last report; "last" marks the final event of the tick.
// Byte transfers are taken every cycle and never stall on the output. A tick
// is taken once the two-entry output buffer (head and one pending entry) has
// drained or while its head leaves with nothing pending; a tick that yields
// two events holds them in head and pending. Bytes flow at one per cycle.
module ps2_mouse_packet_accumulator #(
  parameter int unsigned TOTAL_WIDTH = ps2ma_pkg::TOTAL_WIDTH_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output      logic                                   in_ready,
  input  wire logic                                   op,
  input  wire logic [ps2ma_pkg::BYTE_WIDTH-1:0]       rx_byte,
  output      logic                                   out_valid,
  input  wire logic                                   out_ready,
  output      logic                                   event_kind,
  output      logic signed [ps2ma_pkg::DELTA_WIDTH-1:0] delta_x,
  output      logic signed [ps2ma_pkg::DELTA_WIDTH-1:0] delta_y,
  output      logic [ps2ma_pkg::BUTTON_WIDTH-1:0]     button_bits,
  output      logic                                   last
);

  localparam int unsigned DW   = ps2ma_pkg::DELTA_WIDTH;
  localparam int unsigned BW   = ps2ma_pkg::BYTE_WIDTH;
  localparam int unsigned SUMW = TOTAL_WIDTH + 1;

  // Packet state
  ps2ma_pkg::pos_t                     byte_position;
  logic                                x_sign;
  logic                                y_sign;
  logic [BW-1:0]                       x_byte;
  logic signed [TOTAL_WIDTH-1:0]       x_total;
  logic signed [TOTAL_WIDTH-1:0]       y_total;
  logic [ps2ma_pkg::BUTTON_WIDTH-1:0]  button_now;
  logic [ps2ma_pkg::BUTTON_WIDTH-1:0]  button_reported;

  // Output buffer
  ps2ma_pkg::event_t head;
  ps2ma_pkg::event_t pend;
  logic              pend_valid;

  // Handshake
  logic in_take;
  logic byte_take;
  logic tick_take;
  logic out_take;

  assign out_take  = out_valid && out_ready;
  assign in_ready  = (ps2ma_pkg::op_t'(op) == ps2ma_pkg::OP_BYTE) ||
                     !out_valid || (!pend_valid && out_ready);
  assign in_take   = in_valid && in_ready;
  assign byte_take = in_take && (ps2ma_pkg::op_t'(op) == ps2ma_pkg::OP_BYTE);
  assign tick_take = in_take && (ps2ma_pkg::op_t'(op) == ps2ma_pkg::OP_TICK);

  // Sign-extended 9-bit movements and saturating sums
  logic signed [SUMW-1:0]        mx;
  logic signed [SUMW-1:0]        my;
  logic signed [SUMW-1:0]        x_sum;
  logic signed [SUMW-1:0]        y_sum;
  logic signed [TOTAL_WIDTH-1:0] x_total_next;
  logic signed [TOTAL_WIDTH-1:0] y_total_next;

  always_comb begin
    mx    = {{(SUMW-BW){x_sign}}, x_byte};
    my    = {{(SUMW-BW){y_sign}}, rx_byte};
    x_sum = {x_total[TOTAL_WIDTH-1], x_total} + mx;
    y_sum = {y_total[TOTAL_WIDTH-1], y_total} - my;
    // clamp when the two top bits disagree
    if (x_sum[SUMW-1] != x_sum[SUMW-2]) begin
      x_total_next = {x_sum[SUMW-1], {(TOTAL_WIDTH-1){~x_sum[SUMW-1]}}};
    end else begin
      x_total_next = x_sum[TOTAL_WIDTH-1:0];
    end
    if (y_sum[SUMW-1] != y_sum[SUMW-2]) begin
      y_total_next = {y_sum[SUMW-1], {(TOTAL_WIDTH-1){~y_sum[SUMW-1]}}};
    end else begin
      y_total_next = y_sum[TOTAL_WIDTH-1:0];
    end
  end

  // Fit the totals to the reported width
  logic signed [DW-1:0] x_out;
  logic signed [DW-1:0] y_out;

  generate
    if (TOTAL_WIDTH > DW) begin : g_clamp
      localparam logic signed [TOTAL_WIDTH-1:0] OUT_MAX = TOTAL_WIDTH'(32767);
      localparam logic signed [TOTAL_WIDTH-1:0] OUT_MIN = TOTAL_WIDTH'(-32768);
      always_comb begin
        if (x_total > OUT_MAX) begin
          x_out = OUT_MAX[DW-1:0];
        end else if (x_total < OUT_MIN) begin
          x_out = OUT_MIN[DW-1:0];
        end else begin
          x_out = x_total[DW-1:0];
        end
        if (y_total > OUT_MAX) begin
          y_out = OUT_MAX[DW-1:0];
        end else if (y_total < OUT_MIN) begin
          y_out = OUT_MIN[DW-1:0];
        end else begin
          y_out = y_total[DW-1:0];
        end
      end
    end else if (TOTAL_WIDTH == DW) begin : g_same
      assign x_out = x_total;
      assign y_out = y_total;
    end else begin : g_extend
      assign x_out = {{(DW-TOTAL_WIDTH){x_total[TOTAL_WIDTH-1]}}, x_total};
      assign y_out = {{(DW-TOTAL_WIDTH){y_total[TOTAL_WIDTH-1]}}, y_total};
    end
  endgenerate

  // Events produced by a tick
  logic              want_delta;
  logic              want_button;
  ps2ma_pkg::event_t ev_delta;
  ps2ma_pkg::event_t ev_button;
  ps2ma_pkg::event_t ev0;
  logic              ev0_valid;
  logic              ev1_valid;

  always_comb begin
    want_delta  = (x_total != '0) || (y_total != '0);
    want_button = (button_now != button_reported);

    ev_delta.kind    = ps2ma_pkg::EV_DELTA;
    ev_delta.dx      = x_out;
    ev_delta.dy      = y_out;
    ev_delta.buttons = button_now;
    ev_delta.last    = !want_button;

    ev_button.kind    = ps2ma_pkg::EV_BUTTON;
    ev_button.dx      = '0;
    ev_button.dy      = '0;
    ev_button.buttons = button_now;
    ev_button.last    = 1'b1;

    ev0       = want_delta ? ev_delta : ev_button;
    ev0_valid = want_delta || want_button;
    ev1_valid = want_delta && want_button;
  end

  // Advance packet assembly and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= ps2ma_pkg::POS_HEADER;
      x_total         <= '0;
      y_total         <= '0;
      button_now      <= '0;
      button_reported <= '0;
    end else if (byte_take) begin
      case (byte_position)
        ps2ma_pkg::POS_X: begin
          x_byte        <= rx_byte;
          byte_position <= ps2ma_pkg::POS_Y;
        end
        ps2ma_pkg::POS_Y: begin
          x_total       <= x_total_next;
          y_total       <= y_total_next;
          byte_position <= ps2ma_pkg::POS_HEADER;
        end
        default: begin
          // drop a header that is out of sync
          if (rx_byte[ps2ma_pkg::HDR_SYNC_BIT]) begin
            x_sign        <= rx_byte[ps2ma_pkg::HDR_X_SIGN_BIT];
            y_sign        <= rx_byte[ps2ma_pkg::HDR_Y_SIGN_BIT];
            button_now    <= rx_byte[ps2ma_pkg::BUTTON_WIDTH-1:0];
            byte_position <= ps2ma_pkg::POS_X;
          end else begin
            byte_position <= ps2ma_pkg::POS_HEADER;
          end
        end
      endcase
    end else if (tick_take) begin
      x_total         <= '0;
      y_total         <= '0;
      button_reported <= button_now;
    end
  end

  // Hold events in the output buffer until each transfer completes;
  // a tick's events replace a head that leaves in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (tick_take && ev0_valid) begin
      out_valid  <= 1'b1;
      head       <= ev0;
      pend       <= ev_button;
      pend_valid <= ev1_valid;
    end else if (out_take) begin
      out_valid  <= pend_valid;
      head       <= pend;
      pend_valid <= 1'b0;
    end
  end

  assign event_kind  = head.kind;
  assign delta_x     = head.dx;
  assign delta_y     = head.dy;
  assign button_bits = head.buttons;
  assign last        = head.last;

endmodule

`default_nettype wire

// ===== tb/ps2_mouse_packet_accumulator_tb.sv =====
// Self-checking testbench for the PS/2 mouse packet accumulator.
`default_nettype none

module ps2_mouse_packet_accumulator_tb;
  import ps2ma_pkg::*;

  localparam int unsigned TOT_W = TOTAL_WIDTH_DEFAULT;

  // Predicts movement and button events and checks them against the block
  class mouse_event_scoreboard;
    event_t                  expected_q[$];
    pos_t                    packet_pos;
    logic [BYTE_WIDTH-1:0]   hdr_byte;
    logic [BYTE_WIDTH-1:0]   x_byte;
    longint                  x_total;
    longint                  y_total;
    logic [BUTTON_WIDTH-1:0] buttons_now;
    logic [BUTTON_WIDTH-1:0] buttons_sent;
    int                      failures;

    function new();
      packet_pos   = POS_HEADER;
      hdr_byte     = '0;
      x_byte       = '0;
      x_total      = 0;
      y_total      = 0;
      buttons_now  = '0;
      buttons_sent = '0;
      failures     = 0;
    endfunction

    // Clamp to the signed range of the given width
    function longint sat(longint v, int unsigned w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function string fmt(event_t e);
      return $sformatf("kind=%0d dx=%0d dy=%0d buttons=%0d last=%0d",
                       e.kind, e.dx, e.dy, e.buttons, e.last);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the packet state for one accepted input transfer
    function void note_transfer(op_t code, logic [BYTE_WIDTH-1:0] b);
      longint mx, my;
      bit     want_delta, want_btn;
      event_t ev;
      if (code == OP_BYTE) begin
        case (packet_pos)
          POS_HEADER: begin
            // drop a header that has lost sync
            if (b[HDR_SYNC_BIT]) begin
              hdr_byte    = b;
              buttons_now = b[BUTTON_WIDTH-1:0];
              packet_pos  = POS_X;
            end
          end
          POS_X: begin
            x_byte     = b;
            packet_pos = POS_Y;
          end
          default: begin
            mx = longint'(x_byte) - (hdr_byte[HDR_X_SIGN_BIT] ? 256 : 0);
            my = longint'(b) - (hdr_byte[HDR_Y_SIGN_BIT] ? 256 : 0);
            x_total    = sat(x_total + mx, TOT_W);
            y_total    = sat(y_total - my, TOT_W);
            packet_pos = POS_HEADER;
          end
        endcase
        return;
      end
      // Idle tick: flush movement first, then any button change
      want_delta = (x_total != 0) || (y_total != 0);
      want_btn   = buttons_now != buttons_sent;
      if (want_delta) begin
        ev.kind    = EV_DELTA;
        ev.dx      = sat(x_total, DELTA_WIDTH);
        ev.dy      = sat(y_total, DELTA_WIDTH);
        ev.buttons = buttons_now;
        ev.last    = !want_btn;
        expected_q.push_back(ev);
      end
      x_total = 0;
      y_total = 0;
      if (want_btn) begin
        ev.kind    = EV_BUTTON;
        ev.dx      = '0;
        ev.dy      = '0;
        ev.buttons = buttons_now;
        ev.last    = 1'b1;
        expected_q.push_back(ev);
        buttons_sent = buttons_now;
      end
    endfunction

    // Compare one output transfer with the oldest expected event
    function void check_event(event_t got);
      event_t want;
      if (expected_q.size() == 0) begin
        note_failure({"event with none expected: ", fmt(got)});
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.dx !== want.dx || got.dy !== want.dy ||
          got.buttons !== want.buttons || got.last !== want.last)
        note_failure({"expected ", fmt(want), ", got ", fmt(got)});
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic                           op;
  logic [BYTE_WIDTH-1:0]          rx_byte;
  logic                           out_valid;
  logic                           out_ready;
  logic                           event_kind;
  logic signed [DELTA_WIDTH-1:0]  delta_x;
  logic signed [DELTA_WIDTH-1:0]  delta_y;
  logic [BUTTON_WIDTH-1:0]        button_bits;
  logic                           last;

  mouse_event_scoreboard sb;
  bit                    steady;
  int                    items_sent;

  ps2_mouse_packet_accumulator u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .delta_x     (delta_x),
    .delta_y     (delta_y),
    .button_bits (button_bits),
    .last        (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle gap for either side; none while in a steady stretch
  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 18);
  endfunction

  // Track every transfer on both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_transfer(op_t'(op), rx_byte);
      if (out_valid && out_ready)
        sb.check_event('{event_kind_t'(event_kind), delta_x, delta_y, button_bits, last});
    end
  end

  // Result side: stall at random, then hold ready until a transfer
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Drive one input item; called and returns at a falling edge
  task automatic push_item(input op_t code, input logic [BYTE_WIDTH-1:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic push_packet(input logic [7:0] hdr, input logic [7:0] xb,
                             input logic [7:0] yb);
    push_item(OP_BYTE, hdr);
    push_item(OP_BYTE, xb);
    push_item(OP_BYTE, yb);
    items_sent += 3;
  endtask

  task automatic push_tick();
    push_item(OP_TICK, 8'($urandom()));
    items_sent++;
  endtask

  // Hold the sender until every expected event has been transferred
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mixed traffic: mostly whole packets, with ticks, noise and torn packets
  task automatic run_mixed(input int n);
    int stop, pick;
    logic [7:0] hdr;
    stop   = items_sent + n;
    steady = ($urandom_range(0, 2) == 0);
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      hdr  = 8'($urandom()) | 8'h08;
      if (pick < 55) begin
        push_packet(hdr, 8'($urandom()), 8'($urandom()));
      end else if (pick < 72) begin
        push_tick();
      end else if (pick < 80) begin
        // out-of-sync header, ignored by the block when a header is due
        push_item(OP_BYTE, 8'($urandom()) & 8'hF7);
        items_sent++;
      end else if (pick < 88) begin
        // torn packet: one or two bytes of anything
        repeat ($urandom_range(1, 2)) begin
          push_item(OP_BYTE, 8'($urandom()));
          items_sent++;
        end
      end else if (pick < 94) begin
        // tick in the middle of a packet
        push_item(OP_BYTE, hdr);
        push_tick();
        push_item(OP_BYTE, 8'($urandom()));
        push_item(OP_BYTE, 8'($urandom()));
        items_sent += 3;
      end else begin
        // tiny or zero movement
        push_packet(hdr & 8'hCF, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)));
      end
    end
  endtask

  // Long one-way drift without ticks to drive both totals into saturation
  task automatic run_drift(input bit negative);
    logic [7:0] hdr;
    steady = ($urandom_range(0, 1) == 0);
    repeat (140) begin
      hdr = (8'($urandom()) & 8'hC7) | 8'h08 | (negative ? 8'h30 : 8'h00);
      if (negative)
        push_packet(hdr, 8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
      else
        push_packet(hdr, 8'($urandom_range(240, 255)), 8'($urandom_range(240, 255)));
    end
    push_tick();
  endtask

  initial begin
    sb         = new();
    items_sent = 0;
    steady     = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = OP_BYTE;
    rx_byte    = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty tick, lost sync, sign extremes, overflow bits, buttons
    push_tick();
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hF7);
    push_packet(8'hFF, 8'h00, 8'h00);
    push_tick();
    push_tick();
    push_packet(8'h08, 8'hFF, 8'hFF);
    push_packet(8'hC8, 8'h01, 8'h80);
    push_tick();
    push_packet(8'h0D, 8'h00, 8'h00);
    push_tick();
    push_packet(8'h3A, 8'hFF, 8'h01);
    push_tick();
    drain();

    items_sent = 0;
    run_mixed(150);
    run_drift(1'b0);
    run_mixed(150);
    drain();
    run_drift(1'b1);
    while (items_sent < 1300) run_mixed(80);

    drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Give up after a generous bound
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
